>>> rtl/lcd_window_pixel_streamer_core_assert.svh
// ----------------------------------------------------------------------------
// LCD window pixel streamer assertion macros
// Concurrent checks on clk with reset disable; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef LCD_WINDOW_PIXEL_STREAMER_CORE_ASSERT_SVH
`define LCD_WINDOW_PIXEL_STREAMER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

`define LWPS_ASSERT_IMPLIES(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lwps assertion failed");

`define LWPS_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lwps assertion failed");

`else

`define LWPS_ASSERT_IMPLIES(name, ante, cons)

`define LWPS_ASSERT_NEXT(name, ante, cons)

`endif

`endif

>>> rtl/lwps_pkg.sv
// ----------------------------------------------------------------------------
// LCD window pixel streamer package
// Request and result payload types and link command codes.
// ----------------------------------------------------------------------------
package lwps_pkg;

    localparam logic FUNC_WINDOW = 1'b0;
    localparam logic FUNC_PIXEL  = 1'b1;

    localparam logic [7:0] CMD_COLSET = 8'h2A;
    localparam logic [7:0] CMD_ROWSET = 8'h2B;
    localparam logic [7:0] CMD_MEMWR  = 8'h2C;
    localparam logic [7:0] BYTE_MASK  = 8'hFF;

    localparam int ADDR_W = 15;

    typedef struct packed {
        logic               func;
        logic signed [15:0] left;
        logic signed [15:0] top;
        logic signed [15:0] right;
        logic signed [15:0] bottom;
        logic [15:0]        pixel;
    } item_t;

    typedef struct packed {
        logic              is_data;
        logic [7:0]        out_byte;
        logic              byte_valid;
        logic              fetch_valid;
        logic [ADDR_W-1:0] fetch_addr;
        logic              done_res;
        logic              rejected;
    } res_t;

endpackage

>>> rtl/lcd_window_pixel_streamer_core.sv
// ----------------------------------------------------------------------------
// LCD window pixel streamer core
// Turns window requests into column/row/memory-write commands with coordinate bytes and pixel
// requests into two data bytes each, walking frame-buffer fetch addresses.
// Request channel item_valid/item_ready/item, result channel
// res_valid/res_ready/res, at most one link byte per result.
// A window request yields 11 results, or one rejected result if it is empty
// after clipping; a pixel request yields 2 results, or none while idle.
// The request is registered in the job registers, and then each result in the
// single result register. Throughput: one result per cycle while the receiver is
// ready; an ignored pixel is taken every cycle while no request is being emitted.
// Reset: idle, no window, no result pending.
// A stalled receiver holds the result register; the request side takes a new
// request only when none is being emitted or the current one emits its last result.
// ----------------------------------------------------------------------------
`include "lcd_window_pixel_streamer_core_assert.svh"

module lcd_window_pixel_streamer_core #(
    parameter int PANEL_WIDTH  = 160,
    parameter int PANEL_HEIGHT = 128
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_ready,
    input  lwps_pkg::item_t item,
    output logic            res_valid,
    input  logic            res_ready,
    output lwps_pkg::res_t  res
);

    localparam int CW = (PANEL_WIDTH  > 1) ? $clog2(PANEL_WIDTH)  : 1;
    localparam int RW = (PANEL_HEIGHT > 1) ? $clog2(PANEL_HEIGHT) : 1;
    localparam int PW = (CW + RW > lwps_pkg::ADDR_W) ? CW + RW : lwps_pkg::ADDR_W;

    localparam logic signed [16:0] X_MAX = 17'(PANEL_WIDTH - 1);
    localparam logic signed [16:0] Y_MAX = 17'(PANEL_HEIGHT - 1);

    localparam logic [3:0] STEP_COLSET = 4'd0;
    localparam logic [3:0] STEP_X0_HI  = 4'd1;
    localparam logic [3:0] STEP_X0_LO  = 4'd2;
    localparam logic [3:0] STEP_X1_HI  = 4'd3;
    localparam logic [3:0] STEP_X1_LO  = 4'd4;
    localparam logic [3:0] STEP_ROWSET = 4'd5;
    localparam logic [3:0] STEP_Y0_HI  = 4'd6;
    localparam logic [3:0] STEP_Y0_LO  = 4'd7;
    localparam logic [3:0] STEP_Y1_HI  = 4'd8;
    localparam logic [3:0] STEP_Y1_LO  = 4'd9;
    localparam logic [3:0] STEP_MEMWR  = 4'd10;
    localparam logic [3:0] STEP_PIX_HI = 4'd0;
    localparam logic [3:0] STEP_PIX_LO = 4'd1;
    localparam logic [3:0] STEP_FIRST  = 4'd0;

    typedef enum logic [1:0] {
        JOB_WINDOW,
        JOB_REJECT,
        JOB_PIXEL
    } job_kind_t;

    // window and walk state
    logic [CW-1:0] win_left_reg,   win_left_next;
    logic [CW-1:0] win_right_reg,  win_right_next;
    logic [RW-1:0] win_bottom_reg, win_bottom_next;
    logic [CW-1:0] cur_col_reg,    cur_col_next;
    logic [RW-1:0] cur_row_reg,    cur_row_next;
    logic          active_reg,     active_next;

    // request being emitted
    logic          job_valid_reg,  job_valid_next;
    job_kind_t     job_kind_reg,   job_kind_next;
    logic [3:0]    job_idx_reg,    job_idx_next;
    logic [CW-1:0] job_x0_reg,     job_x0_next;
    logic [CW-1:0] job_x1_reg,     job_x1_next;
    logic [RW-1:0] job_y0_reg,     job_y0_next;
    logic [RW-1:0] job_y1_reg,     job_y1_next;
    logic [15:0]   job_pix_reg,    job_pix_next;
    logic          job_last_reg,   job_last_next;

    // result register
    logic           res_valid_reg, res_valid_next;
    lwps_pkg::res_t res_reg,       res_next;

    logic                 take;
    logic                 out_free;
    logic                 job_end;
    logic [3:0]           job_final;
    logic signed [16:0]   x0_s, x1_s, y0_s, y1_s;
    logic                 win_empty;
    logic                 walk_wrap;
    logic                 walk_last;
    logic [PW-1:0]        addr_full;
    logic [15:0]          x0_w, x1_w, y0_w, y1_w;

    assign out_free   = !res_valid_reg || res_ready;
    assign job_final  = (job_kind_reg == JOB_WINDOW) ? STEP_MEMWR
                      : (job_kind_reg == JOB_PIXEL)  ? STEP_PIX_LO : STEP_FIRST;
    assign job_end    = job_valid_reg && out_free && (job_idx_reg == job_final);
    assign item_ready = !job_valid_reg || job_end;
    assign take       = item_valid && item_ready;

    // clip window
    always_comb
    begin
        x0_s = item.left[15]   ? 17'sd0 : {1'b0, item.left};
        y0_s = item.top[15]    ? 17'sd0 : {1'b0, item.top};
        x1_s = {item.right[15], item.right};
        y1_s = {item.bottom[15], item.bottom};
        if (x1_s > X_MAX)
        begin
            x1_s = X_MAX;
        end
        if (y1_s > Y_MAX)
        begin
            y1_s = Y_MAX;
        end
        win_empty = (x1_s < x0_s) || (y1_s < y0_s);
    end

    assign walk_wrap = cur_col_reg >= win_right_reg;
    assign walk_last = walk_wrap && (cur_row_reg >= win_bottom_reg);

    always_comb
    begin
        win_left_next   = win_left_reg;
        win_right_next  = win_right_reg;
        win_bottom_next = win_bottom_reg;
        cur_col_next    = cur_col_reg;
        cur_row_next    = cur_row_reg;
        active_next     = active_reg;

        job_valid_next  = job_valid_reg;
        job_kind_next   = job_kind_reg;
        job_idx_next    = job_idx_reg;
        job_x0_next     = job_x0_reg;
        job_x1_next     = job_x1_reg;
        job_y0_next     = job_y0_reg;
        job_y1_next     = job_y1_reg;
        job_pix_next    = job_pix_reg;
        job_last_next   = job_last_reg;

        if (job_valid_reg && out_free)
        begin
            job_idx_next = job_idx_reg + 4'd1;
            if (job_end)
            begin
                job_valid_next = 1'b0;
            end
        end

        if (take)
        begin
            job_idx_next = STEP_FIRST;
            if (item.func == lwps_pkg::FUNC_WINDOW)
            begin
                job_valid_next = 1'b1;
                if (win_empty)
                begin
                    job_kind_next = JOB_REJECT;
                    active_next   = 1'b0;
                end
                else
                begin
                    job_kind_next   = JOB_WINDOW;
                    job_x0_next     = x0_s[CW-1:0];
                    job_x1_next     = x1_s[CW-1:0];
                    job_y0_next     = y0_s[RW-1:0];
                    job_y1_next     = y1_s[RW-1:0];
                    win_left_next   = x0_s[CW-1:0];
                    win_right_next  = x1_s[CW-1:0];
                    win_bottom_next = y1_s[RW-1:0];
                    cur_col_next    = x0_s[CW-1:0];
                    cur_row_next    = y0_s[RW-1:0];
                    active_next     = 1'b1;
                end
            end
            else if (active_reg)
            begin
                job_valid_next = 1'b1;
                job_kind_next  = JOB_PIXEL;
                job_pix_next   = item.pixel;
                job_last_next  = walk_last;
                if (walk_wrap)
                begin
                    cur_col_next = win_left_reg;
                    if (!walk_last)
                    begin
                        cur_row_next = cur_row_reg + 1'b1;
                    end
                end
                else
                begin
                    cur_col_next = cur_col_reg + 1'b1;
                end
                job_x0_next = cur_col_next;
                job_y0_next = cur_row_next;
                active_next = !walk_last;
            end
            else
            begin
                job_valid_next = 1'b0;
            end
        end
    end

    assign addr_full = PW'(job_y0_reg) * PW'(PANEL_WIDTH) + PW'(job_x0_reg);
    assign x0_w = 16'(job_x0_reg);
    assign x1_w = 16'(job_x1_reg);
    assign y0_w = 16'(job_y0_reg);
    assign y1_w = 16'(job_y1_reg);

    always_comb
    begin
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        if (out_free)
        begin
            res_valid_next       = job_valid_reg;
            res_next             = '0;
            res_next.byte_valid  = 1'b1;
            res_next.is_data     = 1'b1;
            unique case (job_kind_reg)
                JOB_REJECT:
                begin
                    res_next.byte_valid = 1'b0;
                    res_next.is_data    = 1'b0;
                    res_next.rejected   = 1'b1;
                end
                JOB_PIXEL:
                begin
                    if (job_idx_reg == STEP_PIX_HI)
                    begin
                        res_next.out_byte = job_pix_reg[15:8];
                    end
                    else
                    begin
                        res_next.out_byte    = job_pix_reg[7:0] & lwps_pkg::BYTE_MASK;
                        res_next.done_res    = job_last_reg;
                        res_next.fetch_valid = !job_last_reg;
                        res_next.fetch_addr  = job_last_reg ? '0
                                             : addr_full[lwps_pkg::ADDR_W-1:0];
                    end
                end
                default:
                begin
                    case (job_idx_reg)
                        STEP_COLSET:
                        begin
                            res_next.is_data  = 1'b0;
                            res_next.out_byte = lwps_pkg::CMD_COLSET;
                        end
                        STEP_X0_HI: res_next.out_byte = x0_w[15:8];
                        STEP_X0_LO: res_next.out_byte = x0_w[7:0];
                        STEP_X1_HI: res_next.out_byte = x1_w[15:8];
                        STEP_X1_LO: res_next.out_byte = x1_w[7:0];
                        STEP_ROWSET:
                        begin
                            res_next.is_data  = 1'b0;
                            res_next.out_byte = lwps_pkg::CMD_ROWSET;
                        end
                        STEP_Y0_HI: res_next.out_byte = y0_w[15:8];
                        STEP_Y0_LO: res_next.out_byte = y0_w[7:0];
                        STEP_Y1_HI: res_next.out_byte = y1_w[15:8];
                        STEP_Y1_LO: res_next.out_byte = y1_w[7:0];
                        default:
                        begin
                            res_next.is_data     = 1'b0;
                            res_next.out_byte    = lwps_pkg::CMD_MEMWR;
                            res_next.fetch_valid = 1'b1;
                            res_next.fetch_addr  = addr_full[lwps_pkg::ADDR_W-1:0];
                        end
                    endcase
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_left_reg   <= '0;
            win_right_reg  <= '0;
            win_bottom_reg <= '0;
            cur_col_reg    <= '0;
            cur_row_reg    <= '0;
            active_reg     <= 1'b0;
            job_valid_reg  <= 1'b0;
            job_kind_reg   <= JOB_WINDOW;
            job_idx_reg    <= STEP_FIRST;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            win_left_reg   <= win_left_next;
            win_right_reg  <= win_right_next;
            win_bottom_reg <= win_bottom_next;
            cur_col_reg    <= cur_col_next;
            cur_row_reg    <= cur_row_next;
            active_reg     <= active_next;
            job_valid_reg  <= job_valid_next;
            job_kind_reg   <= job_kind_next;
            job_idx_reg    <= job_idx_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_x0_reg   <= job_x0_next;
        job_x1_reg   <= job_x1_next;
        job_y0_reg   <= job_y0_next;
        job_y1_reg   <= job_y1_next;
        job_pix_reg  <= job_pix_next;
        job_last_reg <= job_last_next;
        res_reg      <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    `LWPS_ASSERT_IMPLIES(a_reject_alone, res_valid && res.rejected,
        !res.byte_valid && !res.fetch_valid && !res.done_res)
    `LWPS_ASSERT_IMPLIES(a_done_no_fetch, res_valid && res.done_res,
        res.is_data && !res.fetch_valid)
    `LWPS_ASSERT_IMPLIES(a_walk_in_window, active_reg,
        cur_col_reg >= win_left_reg && cur_col_reg <= win_right_reg
        && cur_row_reg <= win_bottom_reg)
    `LWPS_ASSERT_NEXT(a_idle_pixel_dropped,
        take && item.func == lwps_pkg::FUNC_PIXEL && !active_reg, !job_valid_reg)
    `LWPS_ASSERT_IMPLIES(a_pixel_steps, job_valid_reg && job_kind_reg == JOB_PIXEL,
        job_idx_reg == STEP_PIX_HI || job_idx_reg == STEP_PIX_LO)

endmodule
